[hw/rtl/assert_macros.svh]
// Assertion helpers included by button_debounce_auto_repeat.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/bdar_pkg.sv]
package bdar_pkg;

    localparam int NUM_BUTTONS = 4;

    localparam int DEB_W   = 8;
    localparam int HOLD_W  = 16;
    localparam int PHASE_W = 8;

    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_CHANGE  = 2'd1,
        CMD_CONSUME = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        REG_DEBOUNCE_TICKS = 2'd0,
        REG_REPEAT_DELAY   = 2'd1,
        REG_REPEAT_PERIOD  = 2'd2
    } cfg_reg_t;

    localparam logic [DEB_W-1:0]   DEBOUNCE_RESET = 8'd5;
    localparam logic [HOLD_W-1:0]  DELAY_RESET    = 16'd50;
    localparam logic [PHASE_W-1:0] PERIOD_RESET   = 8'd10;
    localparam logic [HOLD_W-1:0]  HOLD_MAX       = 16'hFFFF;

endpackage

[hw/rtl/button_debounce_auto_repeat.sv]
// Debounces four active-high buttons and generates auto-repeat presses. Each input word is
// a command in s_tuser (tick, pin change event, consume press flag) with raw levels and a
// button index in s_tdata; every word yields exactly one result word carrying the press,
// held and stable flags after the command plus the consumed bit. The block takes one word
// per cycle: all per-button state is updated in the cycle the word is accepted, and the
// result sits in an output register that presents it on the next cycle. A new word is
// accepted whenever that output register is empty or is being drained in the same cycle,
// so a stalled result holds off the input until it is taken. Configuration writes are taken
// at any time on the cfg channel and must only be issued while the block is idle.
`include "assert_macros.svh"

module button_debounce_auto_repeat (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [3:0] raw_levels, [5:4] button_index, [7:6] zero
    input  logic [1:0]  s_tuser,    // [1:0] command

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [3:0] pressed_flags, [7:4] held_flags,
                                    // [11:8] stable_flags, [12] consumed, [15:13] zero

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int NB = bdar_pkg::NUM_BUTTONS;

    // configuration
    logic [bdar_pkg::DEB_W-1:0]   deb_ticks_reg;
    logic [bdar_pkg::HOLD_W-1:0]  delay_reg;
    logic [bdar_pkg::PHASE_W-1:0] period_reg;

    // per-button state
    logic [NB-1:0]                stable_reg, stable_next;
    logic [NB-1:0]                press_reg,  press_next;
    logic [NB-1:0]                active_reg, active_next;
    logic [bdar_pkg::DEB_W-1:0]   dcount_reg [NB];
    logic [bdar_pkg::DEB_W-1:0]   dcount_next [NB];
    logic [bdar_pkg::HOLD_W-1:0]  hold_reg [NB];
    logic [bdar_pkg::HOLD_W-1:0]  hold_next [NB];
    logic [bdar_pkg::PHASE_W-1:0] phase_reg [NB];
    logic [bdar_pkg::PHASE_W-1:0] phase_next [NB];
    logic [NB-1:0]                held_next;
    logic                         consumed_next;

    // output register
    logic        m_valid_reg;
    logic [15:0] m_data_reg;

    logic                       s_accept;
    bdar_pkg::cmd_t             cmd;
    logic [NB-1:0]              raw;
    logic [1:0]                 idx;
    logic [bdar_pkg::DEB_W-1:0] deb_load;

    assign cmd      = bdar_pkg::cmd_t'(s_tuser);
    assign raw      = s_tdata[NB-1:0];
    assign idx      = s_tdata[5:4];
    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign deb_load = (deb_ticks_reg == '0) ? bdar_pkg::DEB_W'(1) : deb_ticks_reg;

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    always_comb begin
        logic [bdar_pkg::PHASE_W:0] p;
        stable_next   = stable_reg;
        press_next    = press_reg;
        active_next   = active_reg;
        consumed_next = 1'b0;
        p             = '0;
        for (int b = 0; b < NB; b++) begin
            dcount_next[b] = dcount_reg[b];
            hold_next[b]   = hold_reg[b];
            phase_next[b]  = phase_reg[b];
            case (cmd)
                bdar_pkg::CMD_TICK: begin
                    if (active_next[b]) begin
                        if (dcount_next[b] <= bdar_pkg::DEB_W'(1)) begin
                            dcount_next[b] = '0;
                            active_next[b] = 1'b0;
                            if (raw[b] && !stable_next[b]) begin
                                stable_next[b] = 1'b1;
                                press_next[b]  = 1'b1;
                                hold_next[b]   = '0;
                                phase_next[b]  = '0;
                            end else if (!raw[b] && stable_next[b]) begin
                                stable_next[b] = 1'b0;
                                hold_next[b]   = '0;
                                phase_next[b]  = '0;
                            end
                        end else begin
                            dcount_next[b] = dcount_next[b] - bdar_pkg::DEB_W'(1);
                        end
                    end
                    // hold counting sees the state left by the debounce step above
                    if (stable_next[b] && !active_next[b]) begin
                        if (hold_next[b] != bdar_pkg::HOLD_MAX) begin
                            hold_next[b] = hold_next[b] + bdar_pkg::HOLD_W'(1);
                        end
                        if (hold_next[b] > delay_reg) begin
                            p = {1'b0, phase_next[b]} + (bdar_pkg::PHASE_W+1)'(1);
                            if (p >= {1'b0, period_reg}) begin
                                p             = '0;
                                press_next[b] = 1'b1;
                            end
                            phase_next[b] = p[bdar_pkg::PHASE_W-1:0];
                        end else begin
                            phase_next[b] = '0;
                        end
                    end
                end
                bdar_pkg::CMD_CHANGE: begin
                    if (!active_next[b]) begin
                        active_next[b] = 1'b1;
                        dcount_next[b] = deb_load;
                    end
                end
                bdar_pkg::CMD_CONSUME: begin
                    if (idx == 2'(b)) begin
                        consumed_next = press_reg[b];
                        press_next[b] = 1'b0;
                    end
                end
                default: begin
                end
            endcase
            held_next[b] = stable_next[b] && (hold_next[b] > delay_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deb_ticks_reg <= bdar_pkg::DEBOUNCE_RESET;
            delay_reg     <= bdar_pkg::DELAY_RESET;
            period_reg    <= bdar_pkg::PERIOD_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (bdar_pkg::cfg_reg_t'(cfg_index))
                bdar_pkg::REG_DEBOUNCE_TICKS: deb_ticks_reg <= cfg_data[7:0];
                bdar_pkg::REG_REPEAT_DELAY:   delay_reg     <= cfg_data;
                bdar_pkg::REG_REPEAT_PERIOD:  period_reg    <= cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stable_reg <= '0;
            press_reg  <= '0;
            active_reg <= '0;
            for (int b = 0; b < NB; b++) begin
                dcount_reg[b] <= '0;
                hold_reg[b]   <= '0;
                phase_reg[b]  <= '0;
            end
        end else if (s_accept) begin
            stable_reg <= stable_next;
            press_reg  <= press_next;
            active_reg <= active_next;
            for (int b = 0; b < NB; b++) begin
                dcount_reg[b] <= dcount_next[b];
                hold_reg[b]   <= hold_next[b];
                phase_reg[b]  <= phase_next[b];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // load the result word only when a new input word is taken
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_data_reg <= {3'b000, consumed_next, stable_next, held_next, press_next};
        end
    end

    `ASSERT_NEXT(a_consume_clears, aclk, aresetn,
        s_accept && (cmd == bdar_pkg::CMD_CONSUME),
        !press_reg[$past(idx)], "consumed press flag still set")

    `ASSERT_NEXT(a_change_arms_all, aclk, aresetn,
        s_accept && (cmd == bdar_pkg::CMD_CHANGE),
        &active_reg, "pin change left a button without a countdown")

    `ASSERT_IMPL(a_held_needs_stable, aclk, aresetn,
        m_valid_reg,
        (m_data_reg[7:4] & ~m_data_reg[11:8]) == 4'b0000, "held flag on a released button")

    `ASSERT_IMPL(a_consumed_only_on_consume, aclk, aresetn,
        s_accept && (cmd != bdar_pkg::CMD_CONSUME),
        !consumed_next, "consumed bit set by a non-consume word")

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    typedef struct packed {
        bdar_pkg::cmd_t cmd;
        logic [3:0]     raw;
        logic [1:0]     index;
    } button_word_t;

    typedef struct packed {
        logic [3:0] pressed;
        logic [3:0] held;
        logic [3:0] stable;
        logic       consumed;
    } flags_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;

    button_word_t cur_word = '{cmd: bdar_pkg::CMD_TICK, raw: 4'd0, index: 2'd0};
    button_word_t stim_q[$];
    flags_t       expected_flags_q[$];

    // shaping flags, set by stimulus at the falling edge (long_hold_done by the monitor)
    logic tx_steady     = 1'b0;
    logic rx_steady     = 1'b0;
    logic long_hold_go  = 1'b0;
    logic long_hold_done = 1'b0;
    int   hold_cnt      = 0;
    int   err_cnt       = 0;
    int   stim_total    = 0;

    // predicted button state
    logic [7:0]                       set_debounce;
    logic [15:0]                      set_delay;
    logic [7:0]                       set_period;
    logic [bdar_pkg::NUM_BUTTONS-1:0] btn_stable;
    logic [bdar_pkg::NUM_BUTTONS-1:0] btn_flag;
    logic [bdar_pkg::NUM_BUTTONS-1:0] btn_settling;
    logic [7:0]                       btn_settle_cnt [bdar_pkg::NUM_BUTTONS];
    logic [15:0]                      btn_hold       [bdar_pkg::NUM_BUTTONS];
    logic [7:0]                       btn_phase      [bdar_pkg::NUM_BUTTONS];

    assign s_tdata = {2'b00, cur_word.index, cur_word.raw};
    assign s_tuser = cur_word.cmd;

    always #2 aclk = ~aclk;

    button_debounce_auto_repeat u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // advance the button state by one word and return the flags it leaves behind
    function automatic flags_t apply_button_word(button_word_t w);
        flags_t     res;
        logic [8:0] ph;
        res = '0;
        case (w.cmd)
            bdar_pkg::CMD_TICK: begin
                for (int b = 0; b < bdar_pkg::NUM_BUTTONS; b++) begin
                    if (btn_settling[b]) begin
                        if (btn_settle_cnt[b] <= 8'd1) begin
                            btn_settle_cnt[b] = 8'd0;
                            btn_settling[b]   = 1'b0;
                            if (w.raw[b] && !btn_stable[b]) begin
                                btn_stable[b] = 1'b1;
                                btn_flag[b]   = 1'b1;
                                btn_hold[b]   = 16'd0;
                                btn_phase[b]  = 8'd0;
                            end else if (!w.raw[b] && btn_stable[b]) begin
                                btn_stable[b] = 1'b0;
                                btn_hold[b]   = 16'd0;
                                btn_phase[b]  = 8'd0;
                            end
                        end else begin
                            btn_settle_cnt[b] = btn_settle_cnt[b] - 8'd1;
                        end
                    end
                    if (btn_stable[b] && !btn_settling[b]) begin
                        if (btn_hold[b] != 16'hFFFF)
                            btn_hold[b] = btn_hold[b] + 16'd1;
                        if (btn_hold[b] > set_delay) begin
                            ph = {1'b0, btn_phase[b]} + 9'd1;
                            if (ph >= {1'b0, set_period}) begin
                                ph          = 9'd0;
                                btn_flag[b] = 1'b1;
                            end
                            btn_phase[b] = ph[7:0];
                        end else begin
                            btn_phase[b] = 8'd0;
                        end
                    end
                end
            end
            bdar_pkg::CMD_CHANGE: begin
                for (int b = 0; b < bdar_pkg::NUM_BUTTONS; b++) begin
                    if (!btn_settling[b]) begin
                        btn_settling[b]   = 1'b1;
                        btn_settle_cnt[b] = (set_debounce != 8'd0) ? set_debounce : 8'd1;
                    end
                end
            end
            bdar_pkg::CMD_CONSUME: begin
                res.consumed       = btn_flag[w.index];
                btn_flag[w.index]  = 1'b0;
            end
            default: ;
        endcase
        for (int b = 0; b < bdar_pkg::NUM_BUTTONS; b++) begin
            res.pressed[b] = btn_flag[b];
            res.stable[b]  = btn_stable[b];
            res.held[b]    = btn_stable[b] && (btn_hold[b] > set_delay);
        end
        return res;
    endfunction

    // driver: offer queued words, predict each one as it is taken
    always @(posedge aclk) begin : drv
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                expected_flags_q.push_back(apply_button_word(cur_word));
            if (!s_tvalid || s_tready) begin
                if (stim_q.size() != 0 && (tx_steady || $urandom_range(0, 99) >= 15)) begin
                    cur_word <= stim_q.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result word with the oldest prediction
    always @(posedge aclk) begin : mon
        flags_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_flags_q.size() == 0) begin
                    $error("result word %h with no prediction pending", m_tdata);
                    err_cnt = err_cnt + 1;
                end else begin
                    want = expected_flags_q.pop_front();
                    if (m_tdata[3:0] !== want.pressed) begin
                        $error("pressed_flags: expected %h, got %h", want.pressed, m_tdata[3:0]);
                        err_cnt = err_cnt + 1;
                    end
                    if (m_tdata[7:4] !== want.held) begin
                        $error("held_flags: expected %h, got %h", want.held, m_tdata[7:4]);
                        err_cnt = err_cnt + 1;
                    end
                    if (m_tdata[11:8] !== want.stable) begin
                        $error("stable_flags: expected %h, got %h", want.stable, m_tdata[11:8]);
                        err_cnt = err_cnt + 1;
                    end
                    if (m_tdata[12] !== want.consumed) begin
                        $error("consumed: expected %b, got %b", want.consumed, m_tdata[12]);
                        err_cnt = err_cnt + 1;
                    end
                end
            end
            // long hold-off: back up the output so the input stalls
            if (long_hold_go && !long_hold_done) begin
                m_tready <= 1'b0;
                hold_cnt <= hold_cnt + 1;
                if (hold_cnt >= 250)
                    long_hold_done <= 1'b1;
            end else begin
                m_tready <= rx_steady || ($urandom_range(0, 99) >= 15);
            end
        end
    end

    task automatic push_word(bdar_pkg::cmd_t cmd, logic [3:0] raw, logic [1:0] index);
        button_word_t w;
        w.cmd   = cmd;
        w.raw   = raw;
        w.index = index;
        stim_q.push_back(w);
        stim_total++;
    endtask

    task automatic wait_drained();
        while (stim_q.size() != 0 || s_tvalid || expected_flags_q.size() != 0)
            @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    task automatic write_reg(bdar_pkg::cfg_reg_t idx, logic [15:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            bdar_pkg::REG_DEBOUNCE_TICKS: set_debounce = val[7:0];
            bdar_pkg::REG_REPEAT_DELAY:   set_delay    = val;
            bdar_pkg::REG_REPEAT_PERIOD:  set_period   = val[7:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(int deb, int delay, int period);
        write_reg(bdar_pkg::REG_DEBOUNCE_TICKS, 16'(deb));
        write_reg(bdar_pkg::REG_REPEAT_DELAY, 16'(delay));
        write_reg(bdar_pkg::REG_REPEAT_PERIOD, 16'(period));
        @(negedge aclk);
    endtask

    // change event, settle ticks with some bounce, then a hold with consumes mixed in
    task automatic press_run();
        logic [3:0] lvl;
        int         settle;
        int         hold_len;
        int         cap;
        lvl = 4'($urandom);
        push_word(bdar_pkg::CMD_CHANGE, 4'($urandom), 2'($urandom));
        settle = set_debounce + $urandom_range(0, 2);
        if ($urandom_range(0, 7) == 0)
            settle = $urandom_range(0, settle);
        for (int i = 0; i < settle; i++) begin
            if (i + 1 < set_debounce && $urandom_range(0, 9) < 3)
                push_word(bdar_pkg::CMD_TICK, 4'($urandom), 2'($urandom));
            else
                push_word(bdar_pkg::CMD_TICK, lvl, 2'($urandom));
        end
        cap = set_delay + 3 * set_period + 4;
        if (cap > 40)
            cap = 40;
        hold_len = $urandom_range(0, cap);
        for (int i = 0; i < hold_len; i++) begin
            if ($urandom_range(0, 3) == 0)
                push_word(bdar_pkg::CMD_CONSUME, 4'($urandom), 2'($urandom));
            else
                push_word(bdar_pkg::CMD_TICK, lvl, 2'($urandom));
        end
    endtask

    task automatic random_phase(int n_words);
        int stop_at;
        stop_at = stim_total + n_words;
        while (stim_total < stop_at) begin
            if ($urandom_range(0, 99) < 70)
                press_run();
            else
                push_word(bdar_pkg::cmd_t'($urandom_range(0, 3)), 4'($urandom),
                          2'($urandom));
        end
    endtask

    initial begin : stim
        int phase_no;
        set_debounce = bdar_pkg::DEBOUNCE_RESET;
        set_delay    = bdar_pkg::DELAY_RESET;
        set_period   = bdar_pkg::PERIOD_RESET;
        btn_stable   = '0;
        btn_flag     = '0;
        btn_settling = '0;
        for (int b = 0; b < bdar_pkg::NUM_BUTTONS; b++) begin
            btn_settle_cnt[b] = '0;
            btn_hold[b]       = '0;
            btn_phase[b]      = '0;
        end
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed pass at reset settings
        for (int i = 0; i < bdar_pkg::NUM_BUTTONS; i++)
            push_word(bdar_pkg::CMD_CONSUME, 4'hF, 2'(i));
        push_word(bdar_pkg::CMD_CHANGE, 4'hF, 2'd3);
        push_word(bdar_pkg::CMD_CHANGE, 4'h0, 2'd0);        // already settling: no restart
        repeat (5) push_word(bdar_pkg::CMD_TICK, 4'hF, 2'd0);
        push_word(bdar_pkg::CMD_CONSUME, 4'h0, 2'd2);
        push_word(bdar_pkg::CMD_CONSUME, 4'h0, 2'd2);       // flag already taken
        push_word(bdar_pkg::CMD_CHANGE, 4'b0101, 2'd1);
        // release 1 and 3, keep 0 and 2
        repeat (5) push_word(bdar_pkg::CMD_TICK, 4'b0101, 2'd1);
        push_word(bdar_pkg::CMD_TICK, 4'h0, 2'd3);
        push_word(bdar_pkg::CMD_CONSUME, 4'h0, 2'd0);
        wait_drained();

        // extremes
        load_settings(1, 0, 1);
        random_phase(80);
        wait_drained();
        load_settings(255, 65534, 255);
        random_phase(280);
        wait_drained();
        load_settings(1, 65534, 255);
        random_phase(60);
        wait_drained();
        load_settings(255, 0, 1);
        random_phase(280);
        wait_drained();

        phase_no = 0;
        while (stim_total < 1550) begin
            load_settings($urandom_range(1, 4), $urandom_range(0, 12), $urandom_range(1, 4));
            tx_steady    = (phase_no == 1);
            rx_steady    = (phase_no == 1);
            long_hold_go = (phase_no == 2);
            random_phase(150);
            wait_drained();
            phase_no++;
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;

        repeat (10) @(negedge aclk);
        if (err_cnt == 0 && expected_flags_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
